>>> hdl/assert_macros.svh
// Assertion macros used by the block's RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define TZQS_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that prop holds in the cycle after cond.
`define TZQS_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define TZQS_ASSERT(name, prop)
`define TZQS_ASSERT_NEXT(name, cond, prop)
`endif
`endif

>>> hdl/tzqs_pkg.sv
// Types and constants of the timed zone queue sequencer
package tzqs_pkg;

    localparam int REQ_W     = 3;
    localparam int ZONE_ID_W = 4;
    localparam int MINS_W    = 16;
    localparam int TIME_W    = 32;
    localparam int VALVE_W   = 16;
    localparam int SECS_W    = 22;
    localparam int ZCOUNT_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_QUEUE   = 3'd0,
        REQ_CANCEL  = 3'd1,
        REQ_ADVANCE = 3'd2,
        REQ_TICK    = 3'd3,
        REQ_STATUS  = 3'd4
    } req_kind_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZONES_USED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALVE_LEVEL  = 2'd2;

    localparam logic [ZCOUNT_W-1:0] RST_ZONES_USED   = 5'd16;
    localparam logic [MINS_W-1:0]   RST_MAX_DURATION = 16'd240;
    localparam logic                RST_VALVE_LEVEL  = 1'b1;

    localparam logic [TIME_W-1:0] MS_PER_MIN = 32'd60000;
    // floor(x / 1000) = (x * DIV1000_MAGIC) >> DIV1000_SHIFT for any 32-bit x
    localparam logic [TIME_W-1:0] DIV1000_MAGIC = 32'd274877907;
    localparam int                DIV1000_SHIFT = 38;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [ZONE_ID_W-1:0] zone_id;
        logic [MINS_W-1:0]    duration_mins;
        logic [TIME_W-1:0]    now_ms;
    } req_t;

    typedef struct packed {
        logic [ZCOUNT_W-1:0] zones_used;
        logic [MINS_W-1:0]   max_duration_mins;
        logic                valve_active_level;
    } cfg_t;

    // result of one request; remain_ms still needs the divide by 1000
    typedef struct packed {
        logic               ok;
        logic [VALVE_W-1:0] valve_lines;
        logic               zone_running;
        logic               zone_waiting;
        logic [MINS_W-1:0]  zone_minutes;
        logic [TIME_W-1:0]  remain_ms;
    } res_t;

endpackage

>>> hdl/tzqs_core.sv
// Zone queue state: doubly linked FIFO of zones, run flags and timers
`include "assert_macros.svh"

module tzqs_core
    import tzqs_pkg::*;
#(
    parameter int ZONES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  req_t req,
    input  cfg_t cfg,
    output res_t res
);

    localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int LW = $clog2(ZONES + 1);
    localparam int VW = (ZONES > VALVE_W) ? ZONES : VALVE_W;
    localparam logic [LW-1:0] NIL = LW'(ZONES);

    logic [LW-1:0]     head_reg, head_next;
    logic [LW-1:0]     tail_reg, tail_next;
    logic [LW-1:0]     succ_reg [ZONES];
    logic [LW-1:0]     succ_next [ZONES];
    logic [LW-1:0]     pred_reg [ZONES];
    logic [LW-1:0]     pred_next [ZONES];
    logic [ZONES-1:0]  run_reg, run_next;
    logic [ZONES-1:0]  queued_reg, queued_next;
    logic [MINS_W-1:0] len_min_reg [ZONES];
    logic [TIME_W-1:0] len_ms_reg [ZONES];
    logic [TIME_W-1:0] start_reg [ZONES];

    logic              in_range;
    logic              head_valid;
    logic [ZW-1:0]     t;
    logic [LW-1:0]     t_link;
    logic [LW-1:0]     t_succ;
    logic [LW-1:0]     t_pred;
    logic              t_run;
    logic              t_queued;
    logic [MINS_W-1:0] t_len_min;
    logic [TIME_W-1:0] t_len_ms;
    logic [TIME_W-1:0] elapsed;
    logic              expired;
    logic [MINS_W-1:0] clamped;
    logic [TIME_W-1:0] clamped_ms;
    logic [VW-1:0]     run_pad;
    logic [VALVE_W-1:0] valve_word;

    logic              ok;
    logic              do_push;
    logic              do_unlink;
    logic              set_run;
    logic              clr_run;
    logic              wr_len;
    logic              wr_start;
    logic [TIME_W-1:0] start_val;
    logic              status;

    // queue, cancel and status address zone_id; advance and tick address the head
    always_comb
    begin
        in_range   = 32'(req.zone_id) < 32'(ZONES);
        head_valid = head_reg != NIL;
        if (req.req_type inside {REQ_ADVANCE, REQ_TICK})
        begin
            t = ZW'(head_reg);
        end
        else
        begin
            t = ZW'(req.zone_id);
        end
        t_link     = LW'(t);
        t_succ     = succ_reg[t];
        t_pred     = pred_reg[t];
        t_run      = run_reg[t];
        t_queued   = queued_reg[t];
        t_len_min  = len_min_reg[t];
        t_len_ms   = len_ms_reg[t];
        elapsed    = req.now_ms - start_reg[t];
        expired    = elapsed >= t_len_ms;
        clamped    = (req.duration_mins > cfg.max_duration_mins) ?
                     cfg.max_duration_mins : req.duration_mins;
        clamped_ms = TIME_W'(32'(clamped) * MS_PER_MIN);
    end

    always_comb
    begin
        ok        = 1'b0;
        do_push   = 1'b0;
        do_unlink = 1'b0;
        set_run   = 1'b0;
        clr_run   = 1'b0;
        wr_len    = 1'b0;
        wr_start  = 1'b0;
        start_val = '0;
        status    = 1'b0;
        case (req.req_type)
            REQ_QUEUE:
            begin
                if (in_range && req.duration_mins != '0)
                begin
                    ok      = 1'b1;
                    wr_len  = 1'b1;
                    do_push = !t_queued;
                end
            end
            REQ_CANCEL:
            begin
                if (in_range && t_queued)
                begin
                    ok        = 1'b1;
                    clr_run   = 1'b1;
                    do_unlink = 1'b1;
                end
            end
            REQ_ADVANCE:
            begin
                if (head_valid)
                begin
                    ok        = 1'b1;
                    clr_run   = 1'b1;
                    do_unlink = 1'b1;
                end
            end
            REQ_TICK:
            begin
                if (head_valid)
                begin
                    ok = 1'b1;
                    if (!t_run)
                    begin
                        set_run   = 1'b1;
                        wr_start  = 1'b1;
                        start_val = req.now_ms;
                    end
                    else if (expired)
                    begin
                        clr_run   = 1'b1;
                        wr_start  = 1'b1;
                        do_unlink = 1'b1;
                    end
                end
            end
            REQ_STATUS:
            begin
                if (in_range && {1'b0, req.zone_id} < cfg.zones_used)
                begin
                    ok     = 1'b1;
                    status = 1'b1;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // link updates, every element computed in one combinational pass
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        run_next    = run_reg;
        queued_next = queued_reg;
        for (int i = 0; i < ZONES; i++)
        begin
            succ_next[i] = succ_reg[i];
            pred_next[i] = pred_reg[i];
            if (do_push)
            begin
                if (ZW'(i) == t)
                begin
                    succ_next[i] = NIL;
                    pred_next[i] = tail_reg;
                end
                else if (LW'(i) == tail_reg)
                begin
                    succ_next[i] = t_link;
                end
            end
            if (do_unlink)
            begin
                if (ZW'(i) == t)
                begin
                    succ_next[i] = NIL;
                    pred_next[i] = NIL;
                end
                else
                begin
                    if (LW'(i) == t_pred)
                    begin
                        succ_next[i] = t_succ;
                    end
                    if (LW'(i) == t_succ)
                    begin
                        pred_next[i] = t_pred;
                    end
                end
            end
        end
        if (do_push)
        begin
            queued_next[t] = 1'b1;
            if (!head_valid)
            begin
                head_next = t_link;
            end
            tail_next = t_link;
        end
        if (do_unlink)
        begin
            queued_next[t] = 1'b0;
            if (head_reg == t_link)
            begin
                head_next = t_succ;
            end
            if (tail_reg == t_link)
            begin
                tail_next = t_pred;
            end
        end
        if (set_run)
        begin
            run_next[t] = 1'b1;
        end
        if (clr_run)
        begin
            run_next[t] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= NIL;
            tail_reg   <= NIL;
            run_reg    <= '0;
            queued_reg <= '0;
            for (int i = 0; i < ZONES; i++)
            begin
                succ_reg[i]    <= NIL;
                pred_reg[i]    <= NIL;
                len_min_reg[i] <= '0;
                len_ms_reg[i]  <= '0;
                start_reg[i]   <= '0;
            end
        end
        else if (step)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            run_reg    <= run_next;
            queued_reg <= queued_next;
            for (int i = 0; i < ZONES; i++)
            begin
                succ_reg[i] <= succ_next[i];
                pred_reg[i] <= pred_next[i];
            end
            if (wr_len)
            begin
                len_min_reg[t] <= clamped;
                len_ms_reg[t]  <= clamped_ms;
            end
            if (wr_start)
            begin
                start_reg[t] <= start_val;
            end
        end
    end

    // drive levels reflect the run flags after this request
    always_comb
    begin
        run_pad    = VW'(run_next);
        valve_word = cfg.valve_active_level ? run_pad[VALVE_W-1:0] : ~run_pad[VALVE_W-1:0];

        res.ok           = ok;
        res.valve_lines  = valve_word;
        res.zone_running = status & t_run;
        res.zone_waiting = status & t_queued;
        res.zone_minutes = status ? t_len_min : '0;
        res.remain_ms    = (status && t_run && !expired) ? (t_len_ms - elapsed) : '0;
    end

    `TZQS_ASSERT(a_head_tail_empty_together, (head_reg == NIL) == (tail_reg == NIL))
    `TZQS_ASSERT(a_one_valve_open, $onehot0(run_reg))
    `TZQS_ASSERT(a_running_is_queued, (run_reg & ~queued_reg) == '0)
    `TZQS_ASSERT_NEXT(a_cancel_dequeues, step && ok && req.req_type == REQ_CANCEL, !queued_reg[$past(t)])

endmodule

>>> hdl/timed_zone_queue_sequencer.sv
// Top level of the timed zone queue sequencer: stream ports, config registers, result pipeline
//
// Keeps a first-in first-out queue of valve zones with run lengths and opens at most one
// valve, that of the head zone. Each request word on the slave stream (tuser = request kind:
// queue, cancel, advance, tick, status) yields exactly one result word on the master stream
// (tuser = ok). The block takes one request per cycle unless the master side stalls and
// passes each request through three registers in order: the input register captures it, the
// zone table reads it from there and is updated in a single pass with the result going into
// the middle register, and the remaining time is divided by 1000 through a reciprocal multiply
// on its way into the output register. The queue is a doubly linked list of ZONES entries held
// in flip-flops; all of its pointer updates for one request are made in that single pass. Ready
// runs back from the output: a stalled master side holds the pipeline and the slave side stops
// once all three stages are full. Configuration writes (zones in use, max_duration_mins,
// valve_active_level) are taken in any cycle on the cfg channel and must only be issued while
// no request is in flight; indexes beyond the list are dropped. Valve bits above ZONES always
// show the closed level.

module timed_zone_queue_sequencer
    import tzqs_pkg::*;
#(
    parameter int ZONES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,   // zone_id[3:0], duration_mins[19:4], now_ms[51:20], zero pad
    input  logic [REQ_W-1:0]      s_tuser,   // req_type[2:0]
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,   // valve_lines[15:0], zone_running[16], zone_waiting[17],
                                             // zone_minutes[33:18], seconds_left[55:34]
    output logic                  m_tuser,   // ok
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    req_t               in_req_reg;
    logic               mid_valid_reg;
    res_t               mid_res_reg;
    logic               out_valid_reg;
    logic               out_ok_reg;
    logic [VALVE_W-1:0] out_valve_reg;
    logic               out_running_reg;
    logic               out_waiting_reg;
    logic [MINS_W-1:0]  out_minutes_reg;
    logic [SECS_W-1:0]  out_secs_reg;

    logic               in_accept;
    logic               mid_ready;
    logic               out_ready;
    logic               step;
    logic               mid_fire;
    res_t               core_res;
    logic [63:0]        secs_prod;

    // configuration: always ready, drop unknown indexes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zones_used         <= RST_ZONES_USED;
            cfg_reg.max_duration_mins  <= RST_MAX_DURATION;
            cfg_reg.valve_active_level <= RST_VALVE_LEVEL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ZONES_USED:   cfg_reg.zones_used         <= cfg_data[ZCOUNT_W-1:0];
                CFG_MAX_DURATION: cfg_reg.max_duration_mins  <= cfg_data[MINS_W-1:0];
                CFG_VALVE_LEVEL:  cfg_reg.valve_active_level <= cfg_data[0];
                default:          cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // ready chains back from the output register
    assign out_ready = !out_valid_reg || m_tready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign s_tready  = !in_valid_reg || mid_ready;
    assign in_accept = s_tvalid && s_tready;
    assign step      = in_valid_reg && mid_ready;
    assign mid_fire  = mid_valid_reg && out_ready;

    // input register: hold the request until the zone table takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_req_reg.req_type      <= s_tuser;
            in_req_reg.zone_id       <= s_tdata[3:0];
            in_req_reg.duration_mins <= s_tdata[19:4];
            in_req_reg.now_ms        <= s_tdata[51:20];
        end
    end

    // zone table: reads and updates the queue once per advancing request
    tzqs_core #(
        .ZONES (ZONES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (in_req_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (mid_ready)
        begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            mid_res_reg <= core_res;
        end
    end

    // remaining milliseconds to whole seconds by reciprocal multiply
    assign secs_prod = 64'(mid_res_reg.remain_ms) * 64'(DIV1000_MAGIC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_fire)
        begin
            out_ok_reg      <= mid_res_reg.ok;
            out_valve_reg   <= mid_res_reg.valve_lines;
            out_running_reg <= mid_res_reg.zone_running;
            out_waiting_reg <= mid_res_reg.zone_waiting;
            out_minutes_reg <= mid_res_reg.zone_minutes;
            out_secs_reg    <= secs_prod[DIV1000_SHIFT +: SECS_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {out_secs_reg, out_minutes_reg, out_waiting_reg, out_running_reg,
                       out_valve_reg};

endmodule
